/* sv/uerp_pkg.sv */
package uerp_pkg;

    localparam int SAMPLES_LOG2 = 2;

    localparam int CYCLE_W  = 16;
    localparam int PULSE_W  = 10;
    localparam int SUM_W    = 13;
    localparam int INDEX_W  = 3;
    localparam int DUTY_W   = 8;
    localparam int GAIN_W   = 10;
    localparam int FRAC_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register index map
    localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_GAIN     = 3'd4;

    localparam logic [CYCLE_W-1:0] RST_RISE_TIMEOUT = 16'd3840;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE    = 10'd139;
    localparam logic [CYCLE_W-1:0] RST_CYCLE_TICKS  = 16'd3840;
    localparam logic [PULSE_W-1:0] RST_MIN_DISTANCE = 10'd27;
    localparam logic [GAIN_W-1:0]  RST_PWM_GAIN     = 10'd146;

    typedef struct packed {
        logic [CYCLE_W-1:0] rise_timeout;
        logic [PULSE_W-1:0] max_pulse;
        logic [CYCLE_W-1:0] cycle_ticks;
        logic [PULSE_W-1:0] min_distance;
        logic [GAIN_W-1:0]  pwm_gain;
    } t_cfg;

endpackage

/* sv/uerp_if.sv */
interface uerp_in_if;
    logic valid;
    logic ready;
    logic echo;

    modport source (output valid, output echo, input ready);
    modport sink   (input valid, input echo, output ready);
endinterface

interface uerp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger;
    logic [uerp_pkg::DUTY_W-1:0]   pwm_duty;
    logic                          batch_done;
    logic                          reading_error;

    modport source (output valid, output trigger, output pwm_duty, output batch_done,
                    output reading_error, input ready);
    modport sink   (input valid, input trigger, input pwm_duty, input batch_done,
                    input reading_error, output ready);
endinterface

interface uerp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [uerp_pkg::CFG_IDX_W-1:0]    index;
    logic [uerp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/ultrasonic_echo_ranger_pwm.sv */
// Ultrasonic echo ranger with lamp PWM duty output.
// i_in carries one word per time-base tick: the sampled echo pin level.
// o_out returns exactly one word per input word: trigger pin level, the
// current PWM duty, a batch-done flag and a reading-error flag.
// i_cfg writes the five timing and scaling registers (index 0..4); it is
// always ready and must only be written while no words are in flight.
// An accepted word passes the input register, then the state update and
// result register. Throughput: one word per cycle while the receiver
// does not stall; the state update for each tick is a single pass through
// the phase logic, the batch adder and one 13x10 multiply.
// Reset (synchronous, active low) empties both pipeline registers, sets
// the trigger phase, clears all counters and the duty, and loads the
// register defaults.
// When the receiver stalls, the result word holds and the input register
// still takes one more word; after that i_in.ready drops until o_out moves.
module ultrasonic_echo_ranger_pwm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uerp_in_if.sink     i_in,
    uerp_out_if.source  o_out,
    uerp_cfg_if.sink    i_cfg
);

    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_HIGH    = 2'd2,
        PH_HOLD    = 2'd3
    } t_phase;

    localparam int AVG_W  = uerp_pkg::SUM_W;
    localparam int PROD_W = AVG_W + uerp_pkg::GAIN_W;
    localparam int SCL_W  = PROD_W - uerp_pkg::FRAC_W;
    localparam logic [uerp_pkg::INDEX_W:0] BATCH_LEN = 4'(1 << uerp_pkg::SAMPLES_LOG2);

    uerp_pkg::t_cfg cfg;

    uerp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // pipeline control
    logic r_in_valid;
    logic r_in_echo;
    logic r_out_valid;
    logic out_free;
    logic advance;

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;

    // ranging state
    t_phase                        r_phase,  n_phase;
    logic [uerp_pkg::CYCLE_W-1:0]  r_cycle,  n_cycle;
    logic [uerp_pkg::PULSE_W-1:0]  r_pulse,  n_pulse;
    logic [uerp_pkg::SUM_W-1:0]    r_sum,    n_sum;
    logic [uerp_pkg::INDEX_W-1:0]  r_idx,    n_idx;
    logic [uerp_pkg::DUTY_W-1:0]   r_duty,   n_duty;

    // result word
    logic                          r_trig, n_trig;
    logic                          r_done, n_done;
    logic                          r_err,  n_err;

    t_phase                        ph;
    logic [uerp_pkg::SUM_W-1:0]    sum_add;
    logic [uerp_pkg::INDEX_W-1:0]  idx_inc;
    logic                          batch_full;
    logic [AVG_W-1:0]              avg;
    logic [AVG_W-1:0]              diff;
    logic [PROD_W-1:0]             prod;
    logic [SCL_W-1:0]              scaled;
    logic [uerp_pkg::DUTY_W-1:0]   duty_calc;

    // duty conversion for a completed batch
    always_comb begin
        sum_add    = r_sum + uerp_pkg::SUM_W'(r_pulse);
        idx_inc    = r_idx + 1'b1;
        batch_full = (idx_inc == '0) || ({1'b0, idx_inc} >= BATCH_LEN);
        avg        = sum_add >> uerp_pkg::SAMPLES_LOG2;
        diff       = avg - AVG_W'(cfg.min_distance);
        prod       = PROD_W'(diff) * PROD_W'(cfg.pwm_gain);
        scaled     = prod[PROD_W-1:uerp_pkg::FRAC_W];
        if (avg <= AVG_W'(cfg.min_distance)) begin
            duty_calc = '0;
        end else if (|scaled[SCL_W-1:uerp_pkg::DUTY_W]) begin
            duty_calc = '1;
        end else begin
            duty_calc = scaled[uerp_pkg::DUTY_W-1:0];
        end
    end

    // per-tick phase update
    always_comb begin
        n_phase = r_phase;
        n_pulse = r_pulse;
        n_sum   = r_sum;
        n_idx   = r_idx;
        n_duty  = r_duty;
        n_trig  = 1'b0;
        n_done  = 1'b0;
        n_err   = 1'b0;

        // a finished hold-off turns this tick into the next trigger
        ph = (r_phase == PH_HOLD && r_cycle >= cfg.cycle_ticks) ? PH_TRIGGER : r_phase;

        unique case (ph)
            PH_TRIGGER: begin
                n_trig  = 1'b1;
                n_pulse = '0;
                n_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (r_in_echo) begin
                    n_pulse = uerp_pkg::PULSE_W'(1);
                    n_phase = PH_HIGH;
                end else if (r_cycle >= cfg.rise_timeout) begin
                    n_err   = 1'b1;
                    n_sum   = '0;
                    n_idx   = '0;
                    n_phase = PH_HOLD;
                end
            end
            PH_HIGH: begin
                if (r_in_echo) begin
                    if (r_pulse >= cfg.max_pulse) begin
                        n_err   = 1'b1;
                        n_sum   = '0;
                        n_idx   = '0;
                        n_phase = PH_HOLD;
                    end else begin
                        n_pulse = r_pulse + 1'b1;
                    end
                end else begin
                    // falling edge: bank the width, close the batch when full
                    n_phase = PH_HOLD;
                    if (batch_full) begin
                        n_duty = duty_calc;
                        n_done = 1'b1;
                        n_sum  = '0;
                        n_idx  = '0;
                    end else begin
                        n_sum  = sum_add;
                        n_idx  = idx_inc;
                    end
                end
            end
            PH_HOLD: ;
            default: ;
        endcase

        // trigger restarts the cycle timer; otherwise count up and saturate
        if (ph == PH_TRIGGER) begin
            n_cycle = uerp_pkg::CYCLE_W'(1);
        end else if (r_cycle != '1) begin
            n_cycle = r_cycle + 1'b1;
        end else begin
            n_cycle = r_cycle;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_echo <= i_in.echo;
        end
    end

    // ranging state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TRIGGER;
            r_cycle     <= '0;
            r_pulse     <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase <= n_phase;
                r_cycle <= n_cycle;
                r_pulse <= n_pulse;
                r_sum   <= n_sum;
                r_idx   <= n_idx;
                r_duty  <= n_duty;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_trig <= n_trig;
            r_done <= n_done;
            r_err  <= n_err;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.trigger       = r_trig;
    assign o_out.pwm_duty      = r_duty;
    assign o_out.batch_done    = r_done;
    assign o_out.reading_error = r_err;

endmodule

/* sv/uerp_cfg_regs.sv */
module uerp_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    uerp_cfg_if.sink        i_cfg,
    output uerp_pkg::t_cfg  o_cfg
);

    uerp_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_timeout <= uerp_pkg::RST_RISE_TIMEOUT;
            r_cfg.max_pulse    <= uerp_pkg::RST_MAX_PULSE;
            r_cfg.cycle_ticks  <= uerp_pkg::RST_CYCLE_TICKS;
            r_cfg.min_distance <= uerp_pkg::RST_MIN_DISTANCE;
            r_cfg.pwm_gain     <= uerp_pkg::RST_PWM_GAIN;
        end else if (i_cfg.valid) begin
            // mask to register width; drop writes beyond the map
            unique case (i_cfg.index)
                uerp_pkg::REG_RISE_TIMEOUT: r_cfg.rise_timeout <= i_cfg.data;
                uerp_pkg::REG_MAX_PULSE:
                    r_cfg.max_pulse <= i_cfg.data[uerp_pkg::PULSE_W-1:0];
                uerp_pkg::REG_CYCLE_TICKS:  r_cfg.cycle_ticks  <= i_cfg.data;
                uerp_pkg::REG_MIN_DISTANCE:
                    r_cfg.min_distance <= i_cfg.data[uerp_pkg::PULSE_W-1:0];
                uerp_pkg::REG_PWM_GAIN:
                    r_cfg.pwm_gain <= i_cfg.data[uerp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* sv/uerp_checker.sv */
module uerp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_trigger,
    input logic [uerp_pkg::DUTY_W-1:0]  i_pwm_duty,
    input logic                         i_batch_done,
    input logic                         i_reading_error
);

    logic                        r_last_duty_vld;
    logic [uerp_pkg::DUTY_W-1:0] r_last_duty;

    // track the duty of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_duty_vld <= 1'b0;
            r_last_duty     <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_duty_vld <= 1'b1;
            r_last_duty     <= i_pwm_duty;
        end
    end

    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_batch_done && i_reading_error))
        else $error("batch_done and reading_error in one word");

    a_trig_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_trigger) |-> (!i_batch_done && !i_reading_error))
        else $error("trigger word carries a batch flag");

    a_duty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_batch_done && r_last_duty_vld)
            |-> (i_pwm_duty == r_last_duty))
        else $error("duty changed without a completed batch");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_pwm_duty)
            && $stable(i_trigger) && $stable(i_batch_done) && $stable(i_reading_error)))
        else $error("stalled output word changed");

endmodule

bind ultrasonic_echo_ranger_pwm uerp_checker u_uerp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_trigger       (o_out.trigger),
    .i_pwm_duty      (o_out.pwm_duty),
    .i_batch_done    (o_out.batch_done),
    .i_reading_error (o_out.reading_error)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    // Far above the slowest correct run (about 2000 words).
    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned MAX_REPORTED = 10;
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned RANDOM_WORDS = 1850;
    localparam int unsigned SETTING_RUNS = 8;
    localparam int unsigned DUTY_MAX     = (1 << uerp_pkg::DUTY_W) - 1;

    typedef enum logic [1:0] {PH_TRIGGER, PH_WAIT, PH_HIGH, PH_HOLD} t_phase;

    typedef struct packed {
        logic                        trigger;
        logic [uerp_pkg::DUTY_W-1:0] pwm_duty;
        logic                        batch_done;
        logic                        reading_error;
    } t_tick_word;

    typedef enum logic {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [uerp_pkg::CFG_IDX_W-1:0]  index;
        logic [uerp_pkg::CFG_DATA_W-1:0] data;
        logic                            echo;
        logic                            typed;   // use the word below instead of the ranger model
        t_tick_word                      word;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    uerp_in_if  echo_in ();
    uerp_out_if tick_out ();
    uerp_cfg_if reg_wr ();

    ultrasonic_echo_ranger_pwm i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (echo_in),
        .o_out   (tick_out),
        .i_cfg   (reg_wr)
    );

    // Ranger model state, starting at its reset values.
    uerp_pkg::t_cfg               ranger_cfg = '{uerp_pkg::RST_RISE_TIMEOUT,
                                                 uerp_pkg::RST_MAX_PULSE,
                                                 uerp_pkg::RST_CYCLE_TICKS,
                                                 uerp_pkg::RST_MIN_DISTANCE,
                                                 uerp_pkg::RST_PWM_GAIN};
    t_phase                       rng_phase        = PH_TRIGGER;
    logic [uerp_pkg::CYCLE_W-1:0] ticks_since_trig = '0;
    logic [uerp_pkg::PULSE_W-1:0] width_cnt        = '0;
    logic [uerp_pkg::SUM_W-1:0]   width_sum        = '0;
    logic [uerp_pkg::INDEX_W-1:0] good_readings    = '0;
    logic [uerp_pkg::DUTY_W-1:0]  lamp_duty        = '0;

    // Echo shaping for the next reading: the tick count at which the echo rises
    // and how many ticks it stays high.
    int unsigned rise_at    = 1;
    int unsigned width_goal = 1;

    t_tick_word  pending_words[$];
    int unsigned fail_count     = 0;
    int unsigned cycles_run     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Directed opening: reset defaults, then short timing to hit a rise timeout,
    // an over-long pulse, an immediate hold-off end, the widest accepted pulse
    // and one full batch. Tick rows leave index and data at zero.
    t_row directed_rows [28] = '{
        '{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},  // echo ignored on trigger
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0}},
        '{ROW_WRITE, uerp_pkg::REG_RISE_TIMEOUT, 16'd2,    1'b0, 1'b0, '0},
        '{ROW_WRITE, uerp_pkg::REG_MAX_PULSE,    16'd3,    1'b0, 1'b0, '0},
        '{ROW_WRITE, uerp_pkg::REG_CYCLE_TICKS,  16'd1,    1'b0, 1'b0, '0},
        '{ROW_WRITE, uerp_pkg::REG_MIN_DISTANCE, 16'd0,    1'b0, 1'b0, '0},
        '{ROW_WRITE, uerp_pkg::REG_PWM_GAIN,     16'd1023, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1}},  // rise timeout
        '{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},  // hold-off ends at once
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1}},  // over-long pulse
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0},                         // width 1
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0},                         // width at max_pulse
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0}},
        '{ROW_TICK,  '0, '0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0, '0, 1'b0, 1'b0, '0}                          // batch completes
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Advance the ranger model by one tick and return the word it produces.
    function automatic t_tick_word advance_ranger(input logic echo);
        t_tick_word  w;
        int unsigned avg;
        int unsigned scaled;
        bit          triggered;
        w         = '0;
        triggered = 1'b0;
        if (rng_phase == PH_HOLD && ticks_since_trig >= ranger_cfg.cycle_ticks)
            rng_phase = PH_TRIGGER;
        case (rng_phase)
            PH_TRIGGER: begin
                w.trigger = 1'b1;
                triggered = 1'b1;
                width_cnt = '0;
                rng_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (echo) begin
                    width_cnt = uerp_pkg::PULSE_W'(1);
                    rng_phase = PH_HIGH;
                end else if (ticks_since_trig >= ranger_cfg.rise_timeout) begin
                    // drop the batch, keep the duty
                    w.reading_error = 1'b1;
                    width_sum       = '0;
                    good_readings   = '0;
                    rng_phase       = PH_HOLD;
                end
            end
            PH_HIGH: begin
                if (echo) begin
                    if (width_cnt >= ranger_cfg.max_pulse) begin
                        w.reading_error = 1'b1;
                        width_sum       = '0;
                        good_readings   = '0;
                        rng_phase       = PH_HOLD;
                    end else begin
                        width_cnt = width_cnt + 1'b1;
                    end
                end else begin
                    width_sum     = width_sum + uerp_pkg::SUM_W'(width_cnt);
                    good_readings = good_readings + 1'b1;
                    if (good_readings >= (1 << uerp_pkg::SAMPLES_LOG2) ||
                        good_readings == 0) begin
                        avg = width_sum >> uerp_pkg::SAMPLES_LOG2;
                        if (avg <= ranger_cfg.min_distance) begin
                            lamp_duty = '0;
                        end else begin
                            scaled = ((avg - ranger_cfg.min_distance) * ranger_cfg.pwm_gain)
                                     >> uerp_pkg::FRAC_W;
                            lamp_duty = (scaled > DUTY_MAX) ? uerp_pkg::DUTY_W'(DUTY_MAX)
                                                            : uerp_pkg::DUTY_W'(scaled);
                        end
                        w.batch_done  = 1'b1;
                        width_sum     = '0;
                        good_readings = '0;
                    end
                    rng_phase = PH_HOLD;
                end
            end
            default: ;
        endcase
        if (triggered)
            ticks_since_trig = uerp_pkg::CYCLE_W'(1);
        else if (ticks_since_trig != '1)
            ticks_since_trig = ticks_since_trig + 1'b1;
        w.pwm_duty = lamp_duty;
        return w;
    endfunction

    // Pick the echo level for the next tick. Mostly follow a planned reading
    // (rise, hold high, fall), now and then a timeout or an over-long pulse,
    // with a little noise on top.
    function automatic logic pick_echo();
        t_phase      upcoming;
        int unsigned cap;
        int unsigned pick;
        logic        lvl;
        upcoming = rng_phase;
        if (upcoming == PH_HOLD && ticks_since_trig >= ranger_cfg.cycle_ticks)
            upcoming = PH_TRIGGER;
        if (upcoming == PH_TRIGGER) begin
            cap = (ranger_cfg.rise_timeout == 0) ? 1 : ranger_cfg.rise_timeout;
            if ($urandom_range(99) < 10)
                rise_at = cap + 1;
            else
                rise_at = $urandom_range(1, (cap < 12) ? cap : 12);
            cap  = (ranger_cfg.max_pulse == 0) ? 1 : ranger_cfg.max_pulse;
            pick = $urandom_range(99);
            if (pick < 8)
                width_goal = cap + 1;
            else if (pick < 20)
                width_goal = $urandom_range(1, cap);
            else
                width_goal = $urandom_range(1, (cap < 24) ? cap : 24);
        end
        if ($urandom_range(99) < 6) begin
            lvl = 1'($urandom_range(1));
        end else begin
            case (upcoming)
                PH_TRIGGER: lvl = 1'($urandom_range(1));
                PH_WAIT:    lvl = (ticks_since_trig >= rise_at);
                PH_HIGH:    lvl = (width_cnt < width_goal);
                default:    lvl = ($urandom_range(15) == 0);
            endcase
        end
        return lvl;
    endfunction

    // Fill the unused upper bits of a 10-bit register write with noise.
    function automatic logic [uerp_pkg::CFG_DATA_W-1:0] with_junk(input int unsigned value);
        return uerp_pkg::CFG_DATA_W'(value) |
               (uerp_pkg::CFG_DATA_W'($urandom_range(63)) << uerp_pkg::PULSE_W);
    endfunction

    // Hold until every expected word has come back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Send one echo word; queue either the typed word or the model's.
    task automatic send_tick(input logic echo, input logic typed, input t_tick_word word);
        t_tick_word modeled;
        modeled = advance_ranger(echo);
        pending_words.push_back(typed ? word : modeled);
        while ($urandom_range(99) < send_idle_pct) begin
            echo_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        echo_in.valid <= 1'b1;
        echo_in.echo  <= echo;
        @(posedge i_clk);
        while (!echo_in.ready)
            @(posedge i_clk);
    endtask

    // Write one register once the block is idle and mirror it into the model.
    task automatic write_reg(input logic [uerp_pkg::CFG_IDX_W-1:0] index,
                             input logic [uerp_pkg::CFG_DATA_W-1:0] data);
        echo_in.valid <= 1'b0;
        wait_drained();
        reg_wr.valid <= 1'b1;
        reg_wr.index <= index;
        reg_wr.data  <= data;
        @(posedge i_clk);
        while (!reg_wr.ready)
            @(posedge i_clk);
        reg_wr.valid <= 1'b0;
        case (index)
            uerp_pkg::REG_RISE_TIMEOUT:
                ranger_cfg.rise_timeout = data[uerp_pkg::CYCLE_W-1:0];
            uerp_pkg::REG_MAX_PULSE:
                ranger_cfg.max_pulse    = data[uerp_pkg::PULSE_W-1:0];
            uerp_pkg::REG_CYCLE_TICKS:
                ranger_cfg.cycle_ticks  = data[uerp_pkg::CYCLE_W-1:0];
            uerp_pkg::REG_MIN_DISTANCE:
                ranger_cfg.min_distance = data[uerp_pkg::PULSE_W-1:0];
            uerp_pkg::REG_PWM_GAIN:
                ranger_cfg.pwm_gain     = data[uerp_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver side: stall at the rate of the current run.
    always @(posedge i_clk) begin
        tick_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every accepted word against the oldest expectation.
    always @(posedge i_clk) begin : word_check
        t_tick_word want;
        t_tick_word got;
        if (i_rst_n && tick_out.valid && tick_out.ready) begin
            got.trigger       = tick_out.trigger;
            got.pwm_duty      = tick_out.pwm_duty;
            got.batch_done    = tick_out.batch_done;
            got.reading_error = tick_out.reading_error;
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTED)
                    $display("word with nothing expected: trig %0b duty %0d done %0b err %0b",
                             got.trigger, got.pwm_duty, got.batch_done, got.reading_error);
            end else begin
                want = pending_words.pop_front();
                if (got.trigger !== want.trigger || got.pwm_duty !== want.pwm_duty ||
                    got.batch_done !== want.batch_done ||
                    got.reading_error !== want.reading_error) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED)
                        $display("mismatch: expected trig %0b duty %0d done %0b err %0b, %s",
                                 want.trigger, want.pwm_duty, want.batch_done,
                                 want.reading_error,
                                 $sformatf("got trig %0b duty %0d done %0b err %0b",
                                           got.trigger, got.pwm_duty, got.batch_done,
                                           got.reading_error));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned rise;
        int unsigned maxp;
        int unsigned cyc;
        int unsigned mind;
        int unsigned gain;
        int unsigned span;
        echo_in.valid  = 1'b0;
        echo_in.echo   = 1'b0;
        reg_wr.valid   = 1'b0;
        reg_wr.index   = '0;
        reg_wr.data    = '0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].index, directed_rows[r].data);
            else
                send_tick(directed_rows[r].echo, directed_rows[r].typed, directed_rows[r].word);
        end

        // Random runs, each under its own register setting and idle pattern.
        for (int run = 0; run < SETTING_RUNS; run++) begin
            case (run)
                0: begin    // zero timeout, zero max pulse, shortest cycle
                    rise = 0; maxp = 0; cyc = 1; mind = 0; gain = 1023;
                end
                1: begin    // long widths into full gain: saturated duty
                    rise = $urandom_range(1, 10); maxp = $urandom_range(20, 40);
                    cyc  = $urandom_range(1, 30); mind = $urandom_range(0, 5); gain = 1023;
                end
                2: begin    // widest max pulse, anything for the scaling
                    rise = $urandom_range(1, 10); maxp = 1023; cyc = $urandom_range(1, 40);
                    mind = $urandom_range(0, 1022); gain = $urandom_range(0, 1023);
                end
                3: begin    // all-ones timing and floor; only the first reading fits
                    rise = 65535; maxp = $urandom_range(1, 30); cyc = 65535;
                    mind = 1023; gain = 0;
                end
                4: begin
                    rise = $urandom_range(1, 16); maxp = $urandom_range(1, 1023);
                    cyc  = $urandom_range(1, 64); mind = $urandom_range(0, 40); gain = 0;
                end
                default: begin
                    rise = $urandom_range(1, 16); maxp = $urandom_range(1, 60);
                    cyc  = $urandom_range(1, 64); mind = $urandom_range(0, 30);
                    gain = $urandom_range(0, 1023);
                end
            endcase
            write_reg(uerp_pkg::REG_RISE_TIMEOUT, uerp_pkg::CFG_DATA_W'(rise));
            write_reg(uerp_pkg::REG_MAX_PULSE, with_junk(maxp));
            write_reg(uerp_pkg::REG_CYCLE_TICKS, uerp_pkg::CFG_DATA_W'(cyc));
            write_reg(uerp_pkg::REG_MIN_DISTANCE, with_junk(mind));
            write_reg(uerp_pkg::REG_PWM_GAIN, with_junk(gain));
            // an index past the map must leave every register alone
            write_reg(uerp_pkg::CFG_IDX_W'(uerp_pkg::REG_PWM_GAIN + 1 + $urandom_range(2)),
                      uerp_pkg::CFG_DATA_W'($urandom));

            case (run % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            span = (run == 3) ? 150 : (RANDOM_WORDS - 150) / (SETTING_RUNS - 1);
            repeat (span) send_tick(pick_echo(), 1'b0, '0);
        end

        echo_in.valid <= 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
